[hdl/elsd_pkg.sv]
// Shared types, constants and the blend function of the load tracker.
// No dependencies.
package elsd_pkg;

    localparam int MAX_DISKS   = 8;
    localparam int DISK_W      = 3;
    localparam int DATA_W      = 64;
    localparam int BYTES_W     = 31;
    localparam int SHIFT_W     = 5;
    localparam int CFG_IDX_W   = 4;
    localparam int WEIGHT_BITS = 10;
    localparam logic [DATA_W-1:0] FULL_WEIGHT = 64'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SHIFT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 4'd1;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_STALE    = 2'd1,
        EV_REC_IO   = 2'd2,
        EV_REC_COOL = 2'd3
    } t_event;

    typedef struct packed {
        logic [DISK_W-1:0]  disk;
        logic [BYTES_W-1:0] bytes;
        logic [DATA_W-1:0]  done_count;
        logic [DATA_W-1:0]  timed_count;
        logic [DATA_W-1:0]  latency_sum;
        logic [DATA_W-1:0]  now_ns;
        logic               last_disk;
        logic               has_io;
        logic               has_timed;
    } t_item;

    typedef struct packed {
        logic [DISK_W-1:0] disk_out;
        logic [DATA_W-1:0] load_avg;
        logic [DATA_W-1:0] iops_avg;
        logic [DATA_W-1:0] latency_avg;
        logic              is_stale;
        t_event            event_res;
        logic              tick_end;
        logic              interval_fast;
    } t_res;

    typedef struct packed {
        logic [SHIFT_W-1:0] weight_shift;
        logic [DATA_W-1:0]  stale_timeout;
    } t_cfg;

    // (old*(1024-a) + x*a) >> 10 with a = 2^min(shift,10), all mod 2^64
    function automatic logic [DATA_W-1:0] f_blend(input logic [DATA_W-1:0] old,
                                                  input logic [DATA_W-1:0] x,
                                                  input logic [SHIFT_W-1:0] shift);
        logic [3:0]        sh;
        logic [DATA_W-1:0] sum;
        sh  = (shift < SHIFT_W'(WEIGHT_BITS)) ? shift[3:0] : 4'(WEIGHT_BITS);
        sum = (old << WEIGHT_BITS) - (old << sh) + (x << sh);
        return sum >> WEIGHT_BITS;
    endfunction

endpackage

[hdl/elsd_front.sv]
// Front end: accepts samples, classifies them and holds them in a two-entry queue.
// Depends on elsd_pkg.
module elsd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  elsd_pkg::t_item       i_item,
    output logic                  o_avail,
    output elsd_pkg::t_item       o_item,
    input  logic                  i_take
);
    import elsd_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       wr, rd;
    t_item      cls;

    always_comb begin
        cls           = i_item;
        cls.has_io    = |i_item.bytes;
        cls.has_timed = |i_item.timed_count;
    end

    assign full    = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr      = push && !full;
    assign rd      = i_take && o_avail;

    always_comb begin
        n_wp  = wr ? ~r_wp : r_wp;
        n_rp  = rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls;
        end
    end
endmodule

[hdl/elsd_div.sv]
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on elsd_pkg.
module elsd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [elsd_pkg::DATA_W-1:0]  i_num,
    input  logic [elsd_pkg::DATA_W-1:0]  i_den,
    output logic                         o_done,
    output logic [elsd_pkg::DATA_W-1:0]  o_quo
);
    import elsd_pkg::*;

    logic              r_busy;
    logic [5:0]        r_step;
    logic [DATA_W-1:0] r_q, r_den;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W:0]   rem_sh, rem_sub;
    logic              ge;
    logic              r_done;

    assign rem_sh  = {r_rem[DATA_W-1:0], r_q[DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = !rem_sub[DATA_W];
    assign o_done  = r_done;
    assign o_quo   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_step == 6'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub : rem_sh;
            r_q   <= {r_q[DATA_W-2:0], ge};
        end
    end
endmodule

[hdl/elsd_back.sv]
// Back end: per-disk averages, stale machine, tick activity and result queue.
// Depends on elsd_pkg and elsd_div.
module elsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  elsd_pkg::t_cfg   i_cfg,
    input  logic             i_avail,
    input  elsd_pkg::t_item  i_item,
    output logic             o_take,
    output logic             empty,
    input  logic             pop,
    output elsd_pkg::t_res   o_res
);
    import elsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_CALC = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_item  r_cur;
    logic [DATA_W-1:0] r_lat;

    logic [DATA_W-1:0] r_load [MAX_DISKS];
    logic [DATA_W-1:0] r_iops [MAX_DISKS];
    logic [DATA_W-1:0] r_latav [MAX_DISKS];
    logic [DATA_W-1:0] r_lastio [MAX_DISKS];
    logic [DATA_W-1:0] r_grace [MAX_DISKS];
    logic [DATA_W-1:0] r_since [MAX_DISKS];
    logic [MAX_DISKS-1:0] r_stale;
    logic [DATA_W-1:0] r_act;

    t_res       r_oq [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;

    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic              start, div_start, in_range, push_res, do_pop;
    logic [DISK_W-1:0] d;
    logic [DATA_W-1:0] t, now, lio, n_load, n_iops, n_latav, act_n, dur;
    logic              det, fire, rec_io, rec_cool, n_flag;
    t_event            ev;
    t_res              res;

    assign start     = (r_state == ST_IDLE) && i_avail && (r_ocnt != 2'd2);
    assign o_take    = start;
    assign div_start = start && i_item.has_timed;

    elsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_item.latency_sum),
        .i_den   (i_item.timed_count),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = i_item.has_timed ? ST_DIV : ST_CALC;
            ST_DIV:  if (div_done) n_state = ST_CALC;
            ST_CALC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        d        = r_cur.disk;
        in_range = ({1'b0, d} < (DISK_W + 1)'(MAX_DISKS));
        t        = i_cfg.stale_timeout;
        now      = r_cur.now_ns;
        det      = |t;
        n_load   = f_blend(r_load[d], DATA_W'(r_cur.bytes), i_cfg.weight_shift);
        n_iops   = f_blend(r_iops[d], r_cur.done_count, i_cfg.weight_shift);
        n_latav  = f_blend(r_latav[d], r_lat, i_cfg.weight_shift);
        lio      = (det && r_cur.has_io) ? now : r_lastio[d];
        dur      = now - r_since[d];
        fire     = det && !r_stale[d] && (|lio) && (now > r_grace[d]) && ((now - lio) > t);
        rec_io   = r_stale[d] && r_cur.has_io;
        rec_cool = r_stale[d] && (dur > (t << 1));
        n_flag   = r_stale[d];
        ev       = EV_NONE;
        if (fire) begin
            n_flag = 1'b1;
            ev     = EV_STALE;
        end else if (rec_io) begin
            n_flag = 1'b0;
            ev     = EV_REC_IO;
        end else if (rec_cool) begin
            n_flag = 1'b0;
            ev     = EV_REC_COOL;
        end
        act_n = r_act + DATA_W'(r_cur.bytes) + r_cur.done_count;

        res               = '0;
        res.disk_out      = d;
        res.tick_end      = r_cur.last_disk;
        res.interval_fast = r_cur.last_disk && (act_n > FULL_WEIGHT);
        if (in_range) begin
            res.load_avg    = n_load;
            res.iops_avg    = n_iops;
            res.latency_avg = n_latav;
            res.is_stale    = n_flag;
            res.event_res   = ev;
        end
    end

    assign push_res = (r_state == ST_CALC);
    assign do_pop   = pop && (r_ocnt != 2'd0);
    assign empty    = (r_ocnt == 2'd0);
    assign o_res    = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
            r_act   <= '0;
            r_stale <= '0;
            for (int i = 0; i < MAX_DISKS; i++) begin
                r_load[i]   <= '0;
                r_iops[i]   <= '0;
                r_latav[i]  <= '0;
                r_lastio[i] <= '0;
                r_grace[i]  <= '0;
                r_since[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (push_res) r_owp <= ~r_owp;
            if (do_pop)   r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, push_res} - {1'b0, do_pop};
            if (push_res) begin
                r_act <= r_cur.last_disk ? '0 : act_n;
                if (in_range) begin
                    r_load[d]   <= n_load;
                    r_iops[d]   <= n_iops;
                    r_latav[d]  <= n_latav;
                    r_lastio[d] <= lio;
                    r_stale[d]  <= n_flag;
                    if (fire) r_since[d] <= now;
                    if (!fire && (rec_io || rec_cool)) r_grace[d] <= now + t;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cur <= i_item;
            r_lat <= '0;
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_lat <= div_quo;
        end
        if (push_res) begin
            r_oq[r_owp] <= res;
        end
    end
endmodule

[hdl/ema_load_tracker_stale_detect_top.sv]
// Top level of the per-disk load tracker with stale detection.
// Depends on elsd_pkg, elsd_front, elsd_back.
//
//  channel   handshake                 payload
//  input     push / full               i_disk .. i_last_disk
//  result    pop / empty               o_disk_out .. o_interval_fast
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample with nonzero timed_count passes through start, the divider steps, divider
// done and update; otherwise through start and update only, one sample at a time.
// Reset is synchronous; it clears queues, averages and stale state, weight_shift reads 3.
// Up to two samples and two results queue; with no pop the back end stalls, then the input.
module ema_load_tracker_stale_detect_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [elsd_pkg::DISK_W-1:0]       i_disk,
    input  logic [elsd_pkg::BYTES_W-1:0]      i_interval_bytes,
    input  logic [elsd_pkg::DATA_W-1:0]       i_done_count,
    input  logic [elsd_pkg::DATA_W-1:0]       i_timed_count,
    input  logic [elsd_pkg::DATA_W-1:0]       i_latency_sum,
    input  logic [elsd_pkg::DATA_W-1:0]       i_now_ns,
    input  logic                              i_last_disk,
    output logic                              empty,
    input  logic                              pop,
    output logic [elsd_pkg::DISK_W-1:0]       o_disk_out,
    output logic [elsd_pkg::DATA_W-1:0]       o_load_avg,
    output logic [elsd_pkg::DATA_W-1:0]       o_iops_avg,
    output logic [elsd_pkg::DATA_W-1:0]       o_latency_avg,
    output logic                              o_is_stale,
    output logic [1:0]                        o_event_res,
    output logic                              o_tick_end,
    output logic                              o_interval_fast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [elsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [elsd_pkg::DATA_W-1:0]       i_cfg_data
);
    import elsd_pkg::*;

    t_cfg  r_cfg;
    t_item in_item, q_item;
    t_res  res;
    logic  avail, take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight_shift  <= SHIFT_W'(3);
            r_cfg.stale_timeout <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WEIGHT_SHIFT:  r_cfg.weight_shift  <= i_cfg_data[SHIFT_W-1:0];
                REG_STALE_TIMEOUT: r_cfg.stale_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item             = '0;
        in_item.disk        = i_disk;
        in_item.bytes       = i_interval_bytes;
        in_item.done_count  = i_done_count;
        in_item.timed_count = i_timed_count;
        in_item.latency_sum = i_latency_sum;
        in_item.now_ns      = i_now_ns;
        in_item.last_disk   = i_last_disk;
    end

    elsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (in_item),
        .o_avail (avail),
        .o_item  (q_item),
        .i_take  (take)
    );

    elsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_avail (avail),
        .i_item  (q_item),
        .o_take  (take),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res)
    );

    assign o_disk_out      = res.disk_out;
    assign o_load_avg      = res.load_avg;
    assign o_iops_avg      = res.iops_avg;
    assign o_latency_avg   = res.latency_avg;
    assign o_is_stale      = res.is_stale;
    assign o_event_res     = res.event_res;
    assign o_tick_end      = res.tick_end;
    assign o_interval_fast = res.interval_fast;
endmodule

[hdl/elsd_checker.sv]
// Port-level checks of the load tracker top level, attached by bind.
// Depends on elsd_pkg and ema_load_tracker_stale_detect_top.
module elsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_is_stale,
    input logic [1:0] o_event_res,
    input logic       o_tick_end,
    input logic       o_interval_fast
);
    import elsd_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_fast_only_at_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_tick_end |-> !o_interval_fast)
        else $error("fast interval outside tick end");

    a_stale_event_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_event_res == EV_STALE) |-> o_is_stale)
        else $error("stale event without stale flag");

    a_recover_event_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_event_res == EV_REC_IO || o_event_res == EV_REC_COOL) |-> !o_is_stale)
        else $error("recovery event with stale flag set");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result dropped without pop");
endmodule

bind ema_load_tracker_stale_detect_top elsd_checker u_elsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_is_stale      (o_is_stale),
    .o_event_res     (o_event_res),
    .o_tick_end      (o_tick_end),
    .o_interval_fast (o_interval_fast)
);
